@@ hw/rtl/wsf_pkg.sv @@
// Shared types and constants for the word substring filter.
package wsf_pkg;

  localparam int CharW         = 8;
  localparam int WindowDepth   = 15;
  localparam int KeyLenW       = 4;
  localparam int WordLenW      = 4;
  localparam int WordIndexW    = 5;
  localparam int DataW         = 64;
  localparam int KeyHighW      = 56;
  localparam int RegIndexW     = 2;

  localparam int DefMaxWordLength = 16;
  localparam int DefMaxWords      = 32;

  localparam logic [CharW-1:0] SpaceCode = 8'd32;
  localparam logic [CharW-1:0] EndCode   = 8'd0;

  // Configuration register indexes
  localparam logic [RegIndexW-1:0] RegKeyLow  = 2'd0;
  localparam logic [RegIndexW-1:0] RegKeyHigh = 2'd1;
  localparam logic [RegIndexW-1:0] RegKeyLen  = 2'd2;

  typedef enum logic [1:0] {
    ST_WORD = 2'd0,
    ST_END  = 2'd1,
    ST_LONG = 2'd2,
    ST_MANY = 2'd3
  } status_t;

  // Per-cycle command to the cell chain
  typedef struct packed {
    logic             shift;
    logic [CharW-1:0] char_in;
  } win_ctrl_t;

endpackage

@@ hw/rtl/wsf_cell.sv @@
// One window cell: holds a character and compares the incoming one with its key character.
module wsf_cell
  import wsf_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic [CharW-1:0] char_in,
  input  logic [CharW-1:0] key_char,
  input  logic             active,
  output logic [CharW-1:0] char_out,
  output logic             hit_ok
);

  logic [CharW-1:0] char_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      char_q <= char_in;
    end
  end

  // Compare the value this cell takes on in this transaction
  assign hit_ok   = !active || (char_in == key_char);
  assign char_out = char_q;

endmodule

@@ hw/rtl/wsf_window.sv @@
// Chain of window cells with key alignment and the hit reduction.
module wsf_window
  import wsf_pkg::*;
(
  input  logic                  clk,
  input  win_ctrl_t             ctrl,
  input  logic [DataW-1:0]      key_low,
  input  logic [KeyHighW-1:0]   key_high,
  input  logic [KeyLenW-1:0]    key_len,
  output logic                  hit
);

  localparam int KeySlots = 1 << KeyLenW;

  logic [CharW-1:0] key_arr  [KeySlots];
  logic [CharW-1:0] link     [WindowDepth+1];
  logic [WindowDepth-1:0] ok;

  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      if (i < 8) begin
        key_arr[i] = key_low[i*CharW +: CharW];
      end else if (i < WindowDepth) begin
        key_arr[i] = key_high[(i-8)*CharW +: CharW];
      end else begin
        key_arr[i] = '0;
      end
    end
  end

  assign link[0] = ctrl.char_in;

  for (genvar j = 0; j < WindowDepth; j++) begin : g_cell
    logic [KeyLenW-1:0] kidx;
    logic               act;

    // Cell j (newest first) lines up with key character key_len-1-j
    assign act  = KeyLenW'(j) < key_len;
    assign kidx = key_len - KeyLenW'(1) - KeyLenW'(j);

    wsf_cell u_cell (
      .clk      (clk),
      .shift    (ctrl.shift),
      .char_in  (link[j]),
      .key_char (key_arr[kidx]),
      .active   (act),
      .char_out (link[j+1]),
      .hit_ok   (ok[j])
    );
  end

  assign hit = &ok;

endmodule

@@ hw/rtl/word_substring_filter_top.sv @@
// Top level of the word substring filter: word control, key registers and result register.
//
// Usage: one character per input transaction on char_code (in_valid/in_stall).
// Space (32) separates words, code 0 ends the string. Each nonempty word gives
// one result on the output channel (out_valid/out_stall) with its index, length
// and whether it contains the configured key. A word reaching MAX_WORD_CHARS
// characters or a word beyond MAX_WORDS gives an error result and output stays
// quiet until the terminator, whose result always carries last = 1.
// A result is registered and appears in the cycle after the character that causes it.
// One character per cycle while no held result is stalled; the key compare runs across
// the 15-cell window chain in the same cycle the character shifts in.
// The receiver may stall: the result register holds its transaction and
// in_stall rises only while a held result is stalled, so a new character is
// taken in the same cycle that a result is drained.
// Reset (rst, synchronous) clears the key registers, word state and the valid
// flag of the result register. Write the key registers through wr_en/wr_index/wr_data
// only while the block is idle.
module word_substring_filter_top
  import wsf_pkg::*;
#(
  parameter int MAX_WORD_CHARS = DefMaxWordLength,
  parameter int MAX_WORDS      = DefMaxWords
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [RegIndexW-1:0]  wr_index,
  input  logic [DataW-1:0]      wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CharW-1:0]      char_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WordIndexW-1:0] word_index,
  output logic [WordLenW-1:0]   word_length,
  output logic                  matched,
  output logic [1:0]            status,
  output logic                  last
);

  localparam int CountW = $clog2(MAX_WORDS + 1);

  logic [DataW-1:0]    key_low;
  logic [KeyHighW-1:0] key_high;
  logic [KeyLenW-1:0]  key_len;

  logic [WordLenW-1:0] cur_len, cur_len_next;
  logic [CountW-1:0]   word_count, word_count_next;
  logic                match_seen, match_seen_next;
  logic                error_hold, error_hold_next;

  logic                  res_valid;
  logic [WordIndexW-1:0] res_index;
  logic [WordLenW-1:0]   res_len;
  logic                  res_match;
  status_t               res_status;
  logic                  res_last;

  logic                  out_valid_q;
  logic [WordIndexW-1:0] word_index_q;
  logic [WordLenW-1:0]   word_length_q;
  logic                  matched_q;
  status_t               status_q;
  logic                  last_q;

  win_ctrl_t win_ctrl;
  logic      hit;
  logic      accept;
  logic      too_long;
  logic      count_full;
  logic [WordLenW:0] len_inc;

  assign in_stall   = out_valid_q && out_stall;
  assign accept     = in_valid && !in_stall;
  assign too_long   = {1'b0, cur_len} >= (WordLenW+1)'(MAX_WORD_CHARS - 1);
  assign count_full = word_count >= CountW'(MAX_WORDS);
  assign len_inc    = {1'b0, cur_len} + (WordLenW+1)'(1);

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegKeyLow:  key_low  <= wr_data;
        RegKeyHigh: key_high <= wr_data[KeyHighW-1:0];
        RegKeyLen:  key_len  <= wr_data[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  // Word control
  always_comb begin
    cur_len_next     = cur_len;
    word_count_next  = word_count;
    match_seen_next  = match_seen;
    error_hold_next  = error_hold;
    win_ctrl.shift   = 1'b0;
    win_ctrl.char_in = char_code;
    res_valid        = 1'b0;
    res_index        = '0;
    res_len          = '0;
    res_match        = 1'b0;
    res_status       = ST_WORD;
    res_last         = 1'b0;

    if (accept) begin
      if (char_code == EndCode) begin
        res_valid = 1'b1;
        res_last  = 1'b1;
        if (error_hold || cur_len == '0) begin
          res_status = ST_END;
        end else if (count_full) begin
          res_status = ST_MANY;
        end else begin
          res_index = WordIndexW'(word_count);
          res_len   = cur_len;
          res_match = match_seen;
        end
        cur_len_next    = '0;
        word_count_next = '0;
        match_seen_next = 1'b0;
        error_hold_next = 1'b0;
      end else if (!error_hold) begin
        if (char_code == SpaceCode) begin
          if (cur_len != '0) begin
            res_valid = 1'b1;
            if (count_full) begin
              res_status      = ST_MANY;
              error_hold_next = 1'b1;
            end else begin
              res_index       = WordIndexW'(word_count);
              res_len         = cur_len;
              res_match       = match_seen;
              word_count_next = word_count + CountW'(1);
            end
            cur_len_next    = '0;
            match_seen_next = 1'b0;
          end
        end else if (too_long) begin
          res_valid       = 1'b1;
          res_status      = ST_LONG;
          error_hold_next = 1'b1;
        end else begin
          win_ctrl.shift = 1'b1;
          cur_len_next   = len_inc[WordLenW-1:0];
          // A hit needs at least key_len characters of this word
          if (hit && len_inc >= {1'b0, key_len}) begin
            match_seen_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len    <= '0;
      word_count <= '0;
      match_seen <= 1'b0;
      error_hold <= 1'b0;
    end else begin
      cur_len    <= cur_len_next;
      word_count <= word_count_next;
      match_seen <= match_seen_next;
      error_hold <= error_hold_next;
    end
  end

  wsf_window u_window (
    .clk      (clk),
    .ctrl     (win_ctrl),
    .key_low  (key_low),
    .key_high (key_high),
    .key_len  (key_len),
    .hit      (hit)
  );

  // Result register: load on a new result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      word_index_q  <= res_index;
      word_length_q <= res_len;
      matched_q     <= res_match;
      status_q      <= res_status;
      last_q        <= res_last;
    end
  end

  assign out_valid   = out_valid_q;
  assign word_index  = word_index_q;
  assign word_length = word_length_q;
  assign matched     = matched_q;
  assign status      = status_q;
  assign last        = last_q;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_len} < (WordLenW+1)'(MAX_WORD_CHARS))
    else $error("word length exceeded its limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    word_count <= CountW'(MAX_WORDS))
    else $error("word count exceeded its limit");

  a_term_result: assert property (@(posedge clk) disable iff (rst)
    accept && char_code == EndCode |=> out_valid && last)
    else $error("terminator did not produce a last result");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_WORD |-> word_length == '0 && !matched && word_index == '0)
    else $error("error result carries word fields");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    accept && char_code == EndCode |=> cur_len == '0 && word_count == '0 && !error_hold)
    else $error("terminator did not clear word state");

endmodule

@@ bench/word_substring_filter_top_tb.sv @@
// Self-checking testbench for the word substring filter: directed table, then random strings.
`timescale 1ns / 1ps

module word_substring_filter_top_tb;
  import wsf_pkg::*;

  localparam int ClkPeriod        = 20;
  localparam int MaxWordLength    = DefMaxWordLength;
  localparam int MaxWords         = DefMaxWords;
  localparam int StallMax         = 8;
  localparam int WatchdogLimit    = 1000;
  localparam int MismatchPrintMax = 10;
  localparam int RandomChars      = 1700;
  localparam int KeyPhases        = 8;

  // Index with no register behind it; writes to it must be ignored
  localparam logic [RegIndexW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [WordIndexW-1:0] word_index;
    logic [WordLenW-1:0]   word_length;
    logic                  matched;
    status_t               status;
    logic                  last;
  } word_report_t;

  typedef enum bit {ROW_CHAR, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [RegIndexW-1:0]  sel;
    logic [DataW-1:0]      value;
    bit                    typed;
    word_report_t          want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [RegIndexW-1:0]  wr_index;
  logic [DataW-1:0]      wr_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [CharW-1:0]      char_code;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WordIndexW-1:0] word_index;
  logic [WordLenW-1:0]   word_length;
  logic                  matched;
  logic [1:0]            status;
  logic                  last;

  word_substring_filter_top dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .word_length(word_length),
    .matched    (matched),
    .status     (status),
    .last       (last)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Filter state mirrored for prediction
  logic [CharW-1:0]    recent_chars [WindowDepth];
  int unsigned         word_len;
  int unsigned         words_done;
  bit                  key_hit;
  bit                  locked_out;
  logic [DataW-1:0]    key_low_q;
  logic [KeyHighW-1:0] key_high_q;
  logic [KeyLenW-1:0]  key_len_q;

  word_report_t expected_reports [$];
  stim_row_t    directed_rows [$];

  int  fail_count;
  int  live_chars;
  int  strings_done;
  int  key_settings;
  int  matched_words;
  int  status_hits [4];
  int  stall_left;
  int  quiet_cycles;
  bit  no_gaps;

  function automatic word_report_t report(int unsigned idx, int unsigned len, bit hit,
                                          status_t st, bit lst);
    word_report_t r;
    r.word_index  = WordIndexW'(idx);
    r.word_length = WordLenW'(len);
    r.matched     = hit;
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  function automatic string show(word_report_t r);
    return $sformatf("index %0d length %0d matched %0b status %0d last %0b",
                     r.word_index, r.word_length, r.matched, r.status, r.last);
  endfunction

  function automatic void flag_failure(string msg);
    fail_count++;
    if (fail_count <= MismatchPrintMax) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic int idle_cycles();
    return no_gaps ? 0 : $urandom_range(0, StallMax);
  endfunction

  function automatic logic [CharW-1:0] key_byte(int unsigned i);
    if (i < 8) return key_low_q[8*i +: 8];
    return key_high_q[8*(i-8) +: 8];
  endfunction

  function automatic void clear_string();
    foreach (recent_chars[i]) recent_chars[i] = '0;
    word_len   = 0;
    words_done = 0;
    key_hit    = 1'b0;
    locked_out = 1'b0;
  endfunction

  function automatic void store_register(logic [RegIndexW-1:0] sel, logic [DataW-1:0] value);
    case (sel)
      RegKeyLow:  key_low_q  = value;
      RegKeyHigh: key_high_q = value[KeyHighW-1:0];
      RegKeyLen:  key_len_q  = value[KeyLenW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the mirrored state by one character; return 1 when it yields a result
  function automatic bit filter_char(logic [CharW-1:0] c, output word_report_t rep);
    int k;
    int i;
    bit hit;
    rep = report(0, 0, 1'b0, ST_WORD, 1'b0);
    if (c == EndCode) begin
      if (locked_out || word_len == 0) rep = report(0, 0, 1'b0, ST_END, 1'b1);
      else if (words_done >= MaxWords) rep = report(0, 0, 1'b0, ST_MANY, 1'b1);
      else rep = report(words_done, word_len, key_hit, ST_WORD, 1'b1);
      clear_string();
      return 1'b1;
    end
    if (locked_out) return 1'b0;
    if (c == SpaceCode) begin
      if (word_len == 0) return 1'b0;
      if (words_done >= MaxWords) begin
        locked_out = 1'b1;
        rep = report(0, 0, 1'b0, ST_MANY, 1'b0);
      end else begin
        rep = report(words_done, word_len, key_hit, ST_WORD, 1'b0);
        words_done++;
      end
      word_len = 0;
      key_hit  = 1'b0;
      return 1'b1;
    end
    if (word_len + 1 >= MaxWordLength) begin
      locked_out = 1'b1;
      rep = report(0, 0, 1'b0, ST_LONG, 1'b0);
      return 1'b1;
    end
    for (i = WindowDepth - 1; i > 0; i--) recent_chars[i] = recent_chars[i-1];
    recent_chars[0] = c;
    word_len++;
    // Newest k characters, oldest first, must equal key characters 0..k-1
    k = key_len_q;
    hit = (word_len >= k);
    for (i = 0; i < k; i++)
      if (recent_chars[k-1-i] != key_byte(i)) hit = 1'b0;
    if (hit) key_hit = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [CharW-1:0] alphabet_char();
    return 8'h61 + CharW'($urandom_range(0, 3));
  endfunction

  function automatic logic [CharW-1:0] word_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return alphabet_char();
    if (r < 9) return CharW'($urandom_range(33, 255));
    return CharW'($urandom_range(1, 31));
  endfunction

  function automatic void add_char(logic [CharW-1:0] c);
    stim_row_t row;
    row.kind  = ROW_CHAR;
    row.sel   = RegKeyLow;
    row.value = DataW'(c);
    row.typed = 1'b0;
    row.want  = report(0, 0, 1'b0, ST_WORD, 1'b0);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic [CharW-1:0] c, status_t st, bit lst);
    stim_row_t row;
    row.kind  = ROW_CHAR;
    row.sel   = RegKeyLow;
    row.value = DataW'(c);
    row.typed = 1'b1;
    row.want  = report(0, 0, 1'b0, st, lst);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write(logic [RegIndexW-1:0] sel, logic [DataW-1:0] value);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.sel   = sel;
    row.value = value;
    row.typed = 1'b0;
    row.want  = report(0, 0, 1'b0, ST_WORD, 1'b0);
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_rows();
    string text;
    int i;
    text = " ab xaby a";
    add_typed(EndCode, ST_END, 1'b1);       // terminator straight after reset
    add_write(RegKeyLow, 64'h6261);         // key "ab"
    add_write(RegKeyHigh, '0);
    add_write(RegKeyLen, 64'd2);
    // leading space, word equal to key, key inside word, key longer than word
    for (i = 0; i < text.len(); i++) add_char(text[i]);
    add_char(EndCode);
    // longest legal word, then one character more
    for (i = 0; i < MaxWordLength - 1; i++) add_char(i[0] ? 8'h01 : 8'hFF);
    add_typed(8'hFF, ST_LONG, 1'b0);
    add_char(SpaceCode);
    add_typed(EndCode, ST_END, 1'b1);
  endfunction

  task automatic send_char(input logic [CharW-1:0] c, input bit typed, input word_report_t want);
    int gap;
    bit produced;
    word_report_t predicted;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (!(locked_out && c != EndCode) && !(c == SpaceCode && word_len == 0)) live_chars++;
    if (c == EndCode) strings_done++;
    produced = filter_char(c, predicted);
    if (typed) expected_reports.push_back(want);
    else if (produced) expected_reports.push_back(predicted);
  endtask

  task automatic put_char(input logic [CharW-1:0] c);
    send_char(c, 1'b0, report(0, 0, 1'b0, ST_WORD, 1'b0));
  endtask

  // Hold the input idle until every predicted result has drained
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIndexW-1:0] sel, input logic [DataW-1:0] value);
    wait_drained();
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= sel;
    wr_data  <= value;
    @(posedge clk);
    store_register(sel, value);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic program_key(input int phase);
    logic [DataW-1:0] low;
    logic [DataW-1:0] high;
    logic [DataW-1:0] len_word;
    int i;
    for (i = 0; i < 8; i++) begin
      low[8*i +: 8]  = alphabet_char();
      high[8*i +: 8] = alphabet_char();
    end
    // upper bits beyond each register's width are random and must be dropped
    len_word = {$urandom, $urandom};
    case (phase)
      0: len_word[KeyLenW-1:0] = 4'd15;
      1: len_word[KeyLenW-1:0] = 4'd0;
      2: len_word[KeyLenW-1:0] = 4'd1;
      3: begin
        low  = '1;
        high = '1;
        len_word[KeyLenW-1:0] = 4'd15;
      end
      4: begin
        low  = {$urandom, $urandom};
        high = {$urandom, $urandom};
      end
      default: len_word[KeyLenW-1:0] = KeyLenW'($urandom_range(1, 6));
    endcase
    write_reg(RegSpare, {$urandom, $urandom});
    write_reg(RegKeyLow, low);
    write_reg(RegKeyHigh, high);
    write_reg(RegKeyLen, len_word);
    key_settings++;
  endtask

  task automatic send_word(input int wlen);
    int k;
    int pos;
    int i;
    bit embed;
    logic [CharW-1:0] c;
    k = key_len_q;
    embed = (k > 0) && ($urandom_range(0, 1) == 1) && (wlen < MaxWordLength);
    if (embed && k > wlen) wlen = k;
    pos = embed ? $urandom_range(0, wlen - k) : 0;
    for (i = 0; i < wlen; i++) begin
      c = (embed && i >= pos && i < pos + k) ? key_byte(i - pos) : word_char();
      if (c == EndCode || c == SpaceCode) c = alphabet_char();
      put_char(c);
    end
  endtask

  task automatic send_string();
    int shape;
    int n_words;
    int wlen;
    int w;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // raw bytes, terminators and spaces included
      repeat ($urandom_range(1, 24)) put_char(CharW'($urandom_range(0, 255)));
    end else begin
      n_words = (shape == 1) ? $urandom_range(MaxWords - 1, MaxWords + 2) : $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) put_char(SpaceCode);
      for (w = 0; w < n_words; w++) begin
        if (shape == 1) wlen = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0) wlen = $urandom_range(12, MaxWordLength + 1);
        else wlen = $urandom_range(1, 8);
        send_word(wlen);
        if (w < n_words - 1 || $urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 2)) put_char(SpaceCode);
      end
    end
    put_char(EndCode);
  endtask

  // Receiver: hold off each result for a drawn number of cycles
  always @(negedge clk) begin
    if (out_valid === 1'b1 && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    word_report_t seen;
    word_report_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen.word_index  = word_index;
      seen.word_length = word_length;
      seen.matched     = matched;
      seen.status      = status_t'(status);
      seen.last        = last;
      stall_left = idle_cycles();
      if (!$isunknown(status)) status_hits[seen.status]++;
      if (seen.status == ST_WORD && seen.matched === 1'b1) matched_words++;
      if (expected_reports.size() == 0) begin
        flag_failure($sformatf("unexpected result: %s", show(seen)));
      end else begin
        want = expected_reports.pop_front();
        if (seen.word_index !== want.word_index || seen.word_length !== want.word_length ||
            seen.matched !== want.matched || seen.status !== want.status ||
            seen.last !== want.last)
          flag_failure($sformatf("mismatch: expected %s, got %s", show(want), show(seen)));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int phase;
    int phase_start;
    rst       = 1'b1;
    wr_en     = 1'b0;
    wr_index  = RegKeyLow;
    wr_data   = '0;
    in_valid  = 1'b0;
    char_code = EndCode;
    key_low_q  = '0;
    key_high_q = '0;
    key_len_q  = '0;
    clear_string();
    build_directed_rows();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE)
        write_reg(directed_rows[r].sel, directed_rows[r].value);
      else
        send_char(directed_rows[r].value[CharW-1:0], directed_rows[r].typed,
                  directed_rows[r].want);
    end

    for (phase = 0; phase < KeyPhases; phase++) begin
      no_gaps = (phase % 3 == 2);
      program_key(phase);
      phase_start = live_chars;
      while (live_chars - phase_start < RandomChars / KeyPhases) begin
        send_string();
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
    end

    wait_drained();
    if (expected_reports.size() != 0)
      flag_failure($sformatf("%0d results never arrived", expected_reports.size()));
    $display("Sent %0d live characters in %0d strings under %0d key settings.",
             live_chars, strings_done, key_settings);
    $display("Results: %0d words (%0d matched), %0d bare ends, %0d too long, %0d too many.",
             status_hits[ST_WORD], matched_words, status_hits[ST_END],
             status_hits[ST_LONG], status_hits[ST_MANY]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
